/* src/sorted_value_table_top_assert.svh */
// Assertion macros for the checker file.
`ifndef SORTED_VALUE_TABLE_TOP_ASSERT_SVH
`define SORTED_VALUE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, reset masked.
`define SVT_AST_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define SVT_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/svt_pkg.sv */
package svt_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic               is_last;
    logic               table_empty;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [1:0] {
    PLAN_INS,
    PLAN_DEL,
    PLAN_FULL,
    PLAN_MISS
  } plan_t;

  typedef struct packed {
    logic  load;
    logic  plan;
    plan_t plan_code;
    logic  rd_restart;
    logic  rd_issue;
    logic  emit_v;
    logic  emit_old;
    logic  skip;
    logic  emit_empty;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic kind_remove;
    logic full;
    logic empty;
    logic new_empty;
    logic match;
    logic more_rd;
    logic take_v;
    logic skip;
    logic last_wr;
  } sts_t;

endpackage

/* src/svt_ctrl.sv */
module svt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  svt_pkg::sts_t sts,
  output svt_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_START,
    S_STREAM,
    S_EMPTY,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot;
  logic   emit;

  assign slot      = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign emit      = cmd.emit_v || cmd.emit_old || cmd.emit_empty;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.kind_remove) begin
          if (sts.empty) begin
            cmd.plan      = 1'b1;
            cmd.plan_code = svt_pkg::PLAN_MISS;
            state_nxt     = S_START;
          end else begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_SCAN;
          end
        end else begin
          cmd.plan      = 1'b1;
          cmd.plan_code = sts.full ? svt_pkg::PLAN_FULL : svt_pkg::PLAN_INS;
          state_nxt     = S_START;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.plan       = 1'b1;
          cmd.plan_code  = svt_pkg::PLAN_DEL;
          cmd.rd_restart = 1'b1;
          state_nxt      = S_START;
        end else if (sts.more_rd) begin
          cmd.rd_issue = 1'b1;
        end else begin
          cmd.plan       = 1'b1;
          cmd.plan_code  = svt_pkg::PLAN_MISS;
          cmd.rd_restart = 1'b1;
          state_nxt      = S_START;
        end
      end
      S_START: begin
        if (sts.new_empty) begin
          state_nxt = S_EMPTY;
        end else begin
          cmd.rd_issue = !sts.empty;
          state_nxt    = S_STREAM;
        end
      end
      S_STREAM: begin
        if (sts.take_v) begin
          if (slot) begin
            cmd.emit_v = 1'b1;
            if (sts.last_wr) state_nxt = S_FINISH;
          end
        end else if (sts.skip) begin
          cmd.skip     = 1'b1;
          cmd.rd_issue = sts.more_rd;
        end else if (slot) begin
          cmd.emit_old = 1'b1;
          cmd.rd_issue = sts.more_rd;
          if (sts.last_wr) state_nxt = S_FINISH;
        end
      end
      S_EMPTY: begin
        if (slot) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/svt_dpath.sv */
module svt_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  svt_pkg::in_t  in_data,
  output svt_pkg::out_t out_data,
  input  svt_pkg::cmd_t cmd,
  output svt_pkg::sts_t sts
);

  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;

  logic signed [31:0] mem [DEPTH];

  logic                bank_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       new_count_r;
  logic [CW-1:0]       rd_ptr_r;
  logic                rd_valid_r;
  logic [CW-1:0]       wr_idx_r;
  logic                done_r;
  logic                kind_r;
  svt_pkg::plan_t      mode_r;
  logic [1:0]          status_r;
  logic signed [31:0]  v_r;
  logic signed [31:0]  rd_data_r;
  svt_pkg::out_t       out_r;

  logic                wr_en;
  logic signed [31:0]  wr_data;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic                eq_v;

  assign eq_v    = (rd_data_r == v_r);
  assign wr_en   = cmd.emit_v || cmd.emit_old;
  assign wr_data = cmd.emit_v ? v_r : rd_data_r;
  assign wr_addr = {~bank_r, wr_idx_r[IW-1:0]};
  assign rd_addr = {bank_r, rd_ptr_r[IW-1:0]};

  assign sts.kind_remove = (kind_r == svt_pkg::REQ_REMOVE);
  assign sts.full        = (count_r == CW'(CAPACITY));
  assign sts.empty       = (count_r == '0);
  assign sts.new_empty   = (new_count_r == '0);
  assign sts.match       = rd_valid_r && eq_v;
  assign sts.more_rd     = (rd_ptr_r < count_r);
  assign sts.take_v      = (mode_r == svt_pkg::PLAN_INS) && !done_r &&
                           (!rd_valid_r || (rd_data_r > v_r));
  assign sts.skip        = (mode_r == svt_pkg::PLAN_DEL) && !done_r && rd_valid_r && eq_v;
  assign sts.last_wr     = (CW'(wr_idx_r + 1'b1) == new_count_r);

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= 1'b0;
      count_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.load || cmd.rd_restart) begin
        rd_valid_r <= 1'b0;
      end else if (cmd.rd_issue) begin
        rd_valid_r <= 1'b1;
      end else if (cmd.emit_old || cmd.skip) begin
        rd_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        bank_r  <= ~bank_r;
        count_r <= new_count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r      <= in_data.value;
      kind_r   <= in_data.req_type;
      wr_idx_r <= '0;
      done_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_idx_r <= CW'(wr_idx_r + 1'b1);
      end
      if (cmd.emit_v || cmd.skip) begin
        done_r <= 1'b1;
      end
    end

    if (cmd.load || cmd.rd_restart) begin
      rd_ptr_r <= '0;
    end else if (cmd.rd_issue) begin
      rd_ptr_r <= CW'(rd_ptr_r + 1'b1);
    end

    if (cmd.plan) begin
      mode_r <= cmd.plan_code;
      unique case (cmd.plan_code)
        svt_pkg::PLAN_INS: begin
          new_count_r <= CW'(count_r + 1'b1);
          status_r    <= svt_pkg::ST_DONE;
        end
        svt_pkg::PLAN_DEL: begin
          new_count_r <= CW'(count_r - 1'b1);
          status_r    <= svt_pkg::ST_DONE;
        end
        svt_pkg::PLAN_FULL: begin
          new_count_r <= count_r;
          status_r    <= svt_pkg::ST_FULL;
        end
        default: begin
          new_count_r <= count_r;
          status_r    <= svt_pkg::ST_NOT_FOUND;
        end
      endcase
    end

    if (wr_en) begin
      out_r.item_value  <= wr_data;
      out_r.is_last     <= sts.last_wr;
      out_r.table_empty <= 1'b0;
      out_r.status      <= status_r;
    end else if (cmd.emit_empty) begin
      out_r.item_value  <= '0;
      out_r.is_last     <= 1'b1;
      out_r.table_empty <= 1'b1;
      out_r.status      <= status_r;
    end
  end

endmodule

/* src/sorted_value_table_top.sv */
// Channel | Ports                          | Beat
// --------+--------------------------------+---------------------------------
// request | in_valid, in_ready, in_data    | req_type, value
// result  | out_valid, out_ready, out_data | item_value, is_last,
//         |                                | table_empty, status
//
// One request at a time. A remove adds a search pass that reads the stored
// entries one by one until it meets the value or runs out, and the copy pass
// spends a read on the removed entry unless the table ends up empty; the
// single read port of the table sets this.
// Results leave through an output register; a stalled result holds the pass.
// Reset empties the table; entry storage needs no clearing.
module sorted_value_table_top #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  svt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output svt_pkg::out_t out_data
);

  svt_pkg::cmd_t cmd;
  svt_pkg::sts_t sts;

  svt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  svt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

/* src/svt_checker.sv */
`include "sorted_value_table_top_assert.svh"

module svt_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input svt_pkg::out_t out_data
);

  `SVT_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result beat changed")
  `SVT_AST_NOW(a_empty_form, out_valid && out_data.table_empty, out_data.is_last && (out_data.item_value == 32'sd0), "empty beat malformed")
  `SVT_AST_NOW(a_status_code, out_valid, (out_data.status == svt_pkg::ST_DONE) || (out_data.status == svt_pkg::ST_FULL) || (out_data.status == svt_pkg::ST_NOT_FOUND), "bad status code")
  `SVT_AST_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind sorted_value_table_top svt_checker u_svt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
